// ===== rtl/atsamp_pkg.sv =====
// ----------------------------------------------------------------------------
// atsamp_pkg
// Shared types and codes for the alias table sampler: result kinds, input
// modes, fixed port widths and the controller states.
// ----------------------------------------------------------------------------
package atsamp_pkg;

	localparam int WORD_BITS    = 32;
	localparam int IDX_OUT_BITS = 10;
	localparam int CNT_OUT_BITS = 11;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		KIND_BUILT     = 2'd0,
		KIND_SAMPLE    = 2'd1,
		KIND_NOT_READY = 2'd2,
		KIND_DROPPED   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_RD,
		ST_SC_WR,
		ST_POP,
		ST_PAIR_RD,
		ST_PAIR_WR,
		ST_LEFT_WR,
		ST_SM_RD,
		ST_SM_MHI,
		ST_SM_SUM,
		ST_SM_CMP
	} state_t;

endpackage

// ===== rtl/alias_table_sampler.sv =====
// ----------------------------------------------------------------------------
// alias_table_sampler
// Weight loader, alias table builder and sampler over on-chip memories.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall): mode 0 loads one weight, mode 1
// draws one sample from rand_a and rand_b. Output channel (result_valid /
// result_stall) carries kind, sampled_index and entry_count.
// A load gives no result unless it is marked last or is dropped for lack of
// room. A load marked last starts the table build for n entries: it scales
// and classifies each entry, pairs entries, with at most n-1 pairs, writes
// each leftover and finishes. The scale and pair steps are each a read then
// a write-back on the single write port of the scaled value memory.
// A sample runs through column select, memory read, two partial products of
// b*total, a sum and the final compare. A sample with no built table, or an
// empty one, gets a not ready result at once.
// Reset empties the table and the output register; memories are not cleared.
// A finished result waits in the output register while result_stall is
// high; the next item is taken as soon as that register is free or drains.
// ----------------------------------------------------------------------------
module alias_table_sampler
	import atsamp_pkg::*;
#(
	parameter int MAX_ENTRIES = 1024,
	parameter int WEIGHT_BITS = 32,
	parameter int RAND_BITS   = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    mode,
	input  logic [WORD_BITS-1:0]    weight,
	input  logic                    last_weight,
	input  logic [WORD_BITS-1:0]    rand_a,
	input  logic [WORD_BITS-1:0]    rand_b,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [1:0]              kind,
	output logic [IDX_OUT_BITS-1:0] sampled_index,
	output logic [CNT_OUT_BITS-1:0] entry_count
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int SW = WEIGHT_BITS + CW;
	localparam int HW = (SW + 1) / 2;
	localparam int PW = RAND_BITS + SW;

	state_t state_q, state_nxt;

	logic [CW-1:0] cnt_q;
	logic [SW-1:0] total_q;
	logic          ready_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] ns_q, nl_q;
	logic          drop_q;
	logic          left_large_q;
	logic [IW-1:0] col_q;
	logic [RAND_BITS-1:0] b_q;
	logic [PW-1:0] plo_q, phi_q, prod_q;

	logic          result_valid_q;
	kind_t         kind_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] ecnt_q;

	// memories
	logic [SW-1:0] sc_mem [MAX_ENTRIES];
	logic [IW-1:0] al_mem [MAX_ENTRIES];
	logic [IW-1:0] sm_mem [MAX_ENTRIES];
	logic [IW-1:0] lg_mem [MAX_ENTRIES];

	logic [SW-1:0] sc_rd0_q, sc_rd1_q;
	logic [IW-1:0] al_rd_q, sm_rd_q, lg_rd_q;

	logic          sc_re, sc_we, al_re, al_we, sm_re, sm_we, lg_re, lg_we;
	logic [IW-1:0] sc_a0, sc_a1, sc_wa, al_wa, sm_wa, sm_ra, lg_wa, lg_ra;
	logic [SW-1:0] sc_wd;
	logic [IW-1:0] al_wd, sm_wd, lg_wd;

	logic          emit;
	kind_t         emit_kind;
	logic [IW-1:0] emit_idx;
	logic [CW-1:0] emit_cnt;

	// input side
	logic                   accept;
	logic [WEIGHT_BITS-1:0] w_in;
	logic [RAND_BITS-1:0]   a_in;
	logic [CW-1:0]          eff_cnt;
	logic                   ld_drop;
	logic [CW-1:0]          cnt_nxt;
	logic                   not_rdy;
	logic [CW+RAND_BITS-1:0] col_prod;
	logic [CW-1:0]          col_raw;
	logic [CW-1:0]          col_fix;

	// datapath
	logic [SW-1:0] scale_v;
	logic          scale_small;
	logic [SW:0]   pair_sum;
	logic [SW-1:0] pair_new;
	logic          pair_small;
	logic          pair_ok;
	logic [CW-1:0] ns_dec, nl_dec;
	logic [IW-1:0] pick;

	assign item_stall = !((state_q == ST_IDLE) && (!result_valid_q || !result_stall));
	assign accept     = item_valid && !item_stall;

	assign w_in    = weight[WEIGHT_BITS-1:0];
	assign a_in    = rand_a[RAND_BITS-1:0];
	assign eff_cnt = ready_q ? '0 : cnt_q;
	assign ld_drop = (eff_cnt == CW'(MAX_ENTRIES));
	assign cnt_nxt = ld_drop ? eff_cnt : eff_cnt + CW'(1);
	assign not_rdy = !ready_q || (cnt_q == '0);

	assign col_prod = (CW + RAND_BITS)'(cnt_q) * (CW + RAND_BITS)'(a_in);
	assign col_raw  = col_prod[CW+RAND_BITS-1:RAND_BITS];
	assign col_fix  = (col_raw >= cnt_q) ? cnt_q - CW'(1) : col_raw;

	assign scale_v     = SW'(sc_rd0_q[WEIGHT_BITS-1:0]) * SW'(cnt_q);
	assign scale_small = scale_v < total_q;

	// port 0 holds the small entry, port 1 the large one
	assign pair_sum   = {1'b0, sc_rd1_q} + {1'b0, sc_rd0_q} - {1'b0, total_q};
	assign pair_new   = pair_sum[SW-1:0];
	assign pair_small = pair_new < total_q;
	assign pair_ok    = (ns_q != '0) && (nl_q != '0);
	assign ns_dec     = ns_q - CW'(1);
	assign nl_dec     = nl_q - CW'(1);

	assign pick = ((total_q == '0) || (prod_q < {sc_rd0_q, {RAND_BITS{1'b0}}})) ?
		col_q : al_rd_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_LOAD) begin
						if (last_weight)
							state_nxt = ST_SC_RD;
					end else if (!not_rdy) begin
						state_nxt = ST_SM_RD;
					end
				end
			end
			ST_SC_RD:   state_nxt = ST_SC_WR;
			ST_SC_WR:   state_nxt = (k_q == '0) ? ST_POP : ST_SC_RD;
			ST_POP: begin
				if (pair_ok)
					state_nxt = ST_PAIR_RD;
				else if ((nl_q != '0) || (ns_q != '0))
					state_nxt = ST_LEFT_WR;
				else
					state_nxt = ST_IDLE;
			end
			ST_PAIR_RD: state_nxt = ST_PAIR_WR;
			ST_PAIR_WR: state_nxt = ST_POP;
			ST_LEFT_WR: state_nxt = ST_POP;
			ST_SM_RD:   state_nxt = ST_SM_MHI;
			ST_SM_MHI:  state_nxt = ST_SM_SUM;
			ST_SM_SUM:  state_nxt = ST_SM_CMP;
			ST_SM_CMP:  state_nxt = ST_IDLE;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// memory controls and result
	always_comb begin
		sc_re = 1'b0; sc_a0 = '0; sc_a1 = '0;
		sc_we = 1'b0; sc_wa = '0; sc_wd = '0;
		al_re = 1'b0; al_we = 1'b0; al_wa = '0; al_wd = '0;
		sm_re = 1'b0; sm_ra = '0; sm_we = 1'b0; sm_wa = '0; sm_wd = '0;
		lg_re = 1'b0; lg_ra = '0; lg_we = 1'b0; lg_wa = '0; lg_wd = '0;
		emit = 1'b0; emit_kind = KIND_BUILT; emit_idx = '0; emit_cnt = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_LOAD)) begin
					if (!ld_drop) begin
						sc_we = 1'b1;
						sc_wa = eff_cnt[IW-1:0];
						sc_wd = SW'(w_in);
					end else if (!last_weight) begin
						emit      = 1'b1;
						emit_kind = KIND_DROPPED;
						emit_cnt  = eff_cnt;
					end
				end else if (accept && not_rdy) begin
					emit      = 1'b1;
					emit_kind = KIND_NOT_READY;
				end
			end
			ST_SC_RD: begin
				sc_re = 1'b1;
				sc_a0 = k_q;
			end
			ST_SC_WR: begin
				sc_we = 1'b1;
				sc_wa = k_q;
				sc_wd = scale_v;
				al_we = 1'b1;
				al_wa = k_q;
				al_wd = k_q;
				if (scale_small) begin
					sm_we = 1'b1;
					sm_wa = ns_q[IW-1:0];
					sm_wd = k_q;
				end else begin
					lg_we = 1'b1;
					lg_wa = nl_q[IW-1:0];
					lg_wd = k_q;
				end
			end
			ST_POP: begin
				if (pair_ok) begin
					sm_re = 1'b1;
					sm_ra = ns_dec[IW-1:0];
					lg_re = 1'b1;
					lg_ra = nl_dec[IW-1:0];
				end else if (nl_q != '0) begin
					lg_re = 1'b1;
					lg_ra = nl_dec[IW-1:0];
				end else if (ns_q != '0) begin
					sm_re = 1'b1;
					sm_ra = ns_dec[IW-1:0];
				end else begin
					emit      = 1'b1;
					emit_kind = drop_q ? KIND_DROPPED : KIND_BUILT;
				end
			end
			ST_PAIR_RD: begin
				sc_re = 1'b1;
				sc_a0 = sm_rd_q;
				sc_a1 = lg_rd_q;
			end
			ST_PAIR_WR: begin
				sc_we = 1'b1;
				sc_wa = lg_rd_q;
				sc_wd = pair_new;
				al_we = 1'b1;
				al_wa = sm_rd_q;
				al_wd = lg_rd_q;
				if (pair_small) begin
					sm_we = 1'b1;
					sm_wa = ns_q[IW-1:0];
					sm_wd = lg_rd_q;
				end else begin
					lg_we = 1'b1;
					lg_wa = nl_q[IW-1:0];
					lg_wd = lg_rd_q;
				end
			end
			ST_LEFT_WR: begin
				sc_we = 1'b1;
				sc_wa = left_large_q ? lg_rd_q : sm_rd_q;
				sc_wd = total_q;
			end
			ST_SM_RD: begin
				sc_re = 1'b1;
				sc_a0 = col_q;
				al_re = 1'b1;
			end
			ST_SM_CMP: begin
				emit      = 1'b1;
				emit_kind = KIND_SAMPLE;
				emit_idx  = pick;
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (sc_we)
			sc_mem[sc_wa] <= sc_wd;
		if (sc_re) begin
			sc_rd0_q <= sc_mem[sc_a0];
			sc_rd1_q <= sc_mem[sc_a1];
		end
	end

	always_ff @(posedge clk) begin
		if (al_we)
			al_mem[al_wa] <= al_wd;
		if (al_re)
			al_rd_q <= al_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (sm_we)
			sm_mem[sm_wa] <= sm_wd;
		if (sm_re)
			sm_rd_q <= sm_mem[sm_ra];
	end

	always_ff @(posedge clk) begin
		if (lg_we)
			lg_mem[lg_wa] <= lg_wd;
		if (lg_re)
			lg_rd_q <= lg_mem[lg_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			total_q        <= '0;
			ready_q        <= 1'b0;
			ns_q           <= '0;
			nl_q           <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nxt;
			result_valid_q <= emit || (result_valid_q && result_stall);
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_LOAD)) begin
						ready_q <= 1'b0;
						cnt_q   <= cnt_nxt;
						total_q <= (ready_q ? '0 : total_q) + (ld_drop ? '0 : SW'(w_in));
						ns_q    <= '0;
						nl_q    <= '0;
					end
				end
				ST_SC_WR: begin
					if (scale_small)
						ns_q <= ns_q + CW'(1);
					else
						nl_q <= nl_q + CW'(1);
				end
				ST_POP: begin
					if (pair_ok) begin
						ns_q <= ns_dec;
						nl_q <= nl_dec;
					end else if (nl_q != '0) begin
						nl_q <= nl_dec;
					end else if (ns_q != '0) begin
						ns_q <= ns_dec;
					end else begin
						ready_q <= 1'b1;
					end
				end
				ST_PAIR_WR: begin
					// push the large entry back with its remainder
					if (pair_small)
						ns_q <= ns_q + CW'(1);
					else
						nl_q <= nl_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= emit_kind;
			idx_q  <= emit_idx;
			ecnt_q <= emit_cnt;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept && (mode == MODE_LOAD)) begin
					k_q    <= IW'(cnt_nxt - CW'(1));
					drop_q <= ld_drop;
				end else if (accept) begin
					col_q <= col_fix[IW-1:0];
					b_q   <= rand_b[RAND_BITS-1:0];
				end
			end
			ST_SC_WR: k_q <= k_q - IW'(1);
			ST_POP:   left_large_q <= (nl_q != '0);
			ST_SM_RD: plo_q <= PW'(b_q) * PW'(total_q[HW-1:0]);
			ST_SM_MHI: phi_q <= PW'(b_q) * PW'(total_q[SW-1:HW]);
			ST_SM_SUM: prod_q <= plo_q + (phi_q << HW);
			default: ;
		endcase
	end

	assign result_valid  = result_valid_q;
	assign kind          = kind_q;
	assign sampled_index = IDX_OUT_BITS'(idx_q);
	assign entry_count   = CNT_OUT_BITS'(ecnt_q);

endmodule
